FILE: src/rlss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlss_pkg
// Shared types, codes and helpers of the relaxed lower-splitting solver.
// ----------------------------------------------------------------------------
package rlss_pkg;

	localparam int MAX_SIZE_DEF  = 16;
	localparam int FRAC_BITS_DEF = 16;

	// Request operation codes.
	localparam logic [1:0] OP_MATRIX = 2'd0;
	localparam logic [1:0] OP_RHS    = 2'd1;
	localparam logic [1:0] OP_GUESS  = 2'd2;
	localparam logic [1:0] OP_START  = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_SIZE  = 2'd0;
	localparam logic [1:0] REG_SWEEP = 2'd1;
	localparam logic [1:0] REG_TAU   = 2'd2;

	// Run status codes.
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_PIVOT = 2'd1;
	localparam logic [1:0] STATUS_SAT   = 2'd2;

	localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
	localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

	typedef logic [4:0] cnt_t;

	typedef struct packed {
		logic               ovf;
		logic signed [31:0] v;
	} sat_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_C_RD,
		S_C_M1,
		S_C_M2,
		S_C_M3,
		S_C_ACC,
		S_L_RD,
		S_L_M1,
		S_L_ACC,
		S_T_RD,
		S_T_M1,
		S_T_NUM,
		S_DIV,
		S_DIV_END,
		S_ROW_END,
		S_OUT_RD,
		S_OUT_V
	} state_t;

	// Saturate a wide signed value to 32 bits and flag the overflow.
	function automatic sat_t sat32(input logic signed [63:0] x);
		sat_t r;
		if (x > SAT_MAX) begin
			r.ovf = 1'b1;
			r.v   = 32'sh7FFFFFFF;
		end else if (x < SAT_MIN) begin
			r.ovf = 1'b1;
			r.v   = 32'sh80000000;
		end else begin
			r.ovf = 1'b0;
			r.v   = x[31:0];
		end
		return r;
	endfunction

endpackage

FILE: src/rlss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlss_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rlss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/relaxed_lower_splitting_solver_top.sv
`timescale 1ns / 1ps
// A start request runs, per sweep, each row i of n: the products over the row, the
// lower-triangle sum and, when the pivot is nonzero, a bit-serial division; then it
// emits the elements in order, holding while the output is stalled. One request is
// taken at a time; the single shared 32x32 multiplier and the bit-serial divider set
// the run time. Reset is asynchronous and active low; it clears the sequencer and the
// config registers, not the datapath registers or the matrix, RHS or estimate RAMs.
// ----------------------------------------------------------------------------
// relaxed_lower_splitting_solver_top
// Relaxed Gauss-Seidel solver on signed fixed point with a shared multiplier.
// ----------------------------------------------------------------------------
module relaxed_lower_splitting_solver_top #(
	parameter int MAX_SIZE  = rlss_pkg::MAX_SIZE_DEF,
	parameter int FRAC_BITS = rlss_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic [3:0]         row,
	input  logic [3:0]         column,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         element_index,
	output logic signed [31:0] solution_value,
	output logic               last,
	output logic [1:0]         status
);
	import rlss_pkg::*;

	localparam int LIMIT = (MAX_SIZE < 16) ? MAX_SIZE : 16;
	localparam int AW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int MD    = MAX_SIZE * MAX_SIZE;
	localparam int MW    = (MD > 1) ? $clog2(MD) : 1;
	localparam int DW    = 32 + FRAC_BITS;
	localparam int DCW   = $clog2(DW + 1);
	localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

	state_t state_q, state_d;

	logic [4:0]         size_q;
	logic [15:0]        sweeps_q;
	logic signed [31:0] tau_q;

	cnt_t               n_q, i_q, j_q;
	logic [15:0]        s_q;
	logic               sat_q, zp_q;
	logic [MAX_SIZE-1:0] sel_q, row_mask;
	logic signed [31:0] a_q, x_q, mterm_q, piv_q;
	logic signed [63:0] prod_q, acc_q, lsum_q;
	logic [31:0]        rem_q;
	logic [DW-1:0]      quo_q;
	logic [31:0]        dvs_q;
	logic [DCW-1:0]     dcnt_q;
	logic               neg_q;

	logic               accept, is_last;
	logic [4:0]         n_start;
	cnt_t               col_sel;
	logic [MW-1:0]      mat_raddr, mat_waddr;
	logic [AW-1:0]      x_raddr, rhs_raddr, xw_addr, load_addr;
	logic               mat_we, rhs_we, xw_en, load_x;
	logic               x_sel;
	logic               x0_we, x1_we;
	logic [AW-1:0]      x0_waddr, x1_waddr;
	logic [31:0]        x0_wdata, x1_wdata;
	logic signed [31:0] xw_data;
	logic [31:0]        mat_rd, rhs_rd, x0_rd, x1_rd;
	logic signed [31:0] cur_rd, new_rd;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] rnd;
	sat_t               sat_p, sat_m, sat_c, sat_n;
	logic signed [63:0] m_wide, num_wide;
	logic [32:0]        rem_sh;
	logic               ge;
	logic [31:0]        num_mag, piv_mag;
	logic               quo_ovf;

	// Handshake and shared decodes.
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign is_last  = (i_q == n_q - cnt_t'(1));
	assign n_start  = (size_q == 5'd0) ? 5'd1 :
		((32'(size_q) > LIMIT) ? 5'(LIMIT) : size_q);

	// Each row keeps its own bank select, so rows outside the run keep their estimate.
	assign x_sel  = sel_q[x_raddr];
	assign cur_rd = x_sel ? $signed(x1_rd) : $signed(x0_rd);
	assign new_rd = x_sel ? $signed(x0_rd) : $signed(x1_rd);

	// Rows in use by the current run.
	always_comb begin
		for (int r = 0; r < MAX_SIZE; r++) begin
			row_mask[r] = (r < int'(n_q));
		end
	end

	// Shared multiplier rounding and saturation.
	assign rnd      = (prod_q + HALF) >>> FRAC_BITS;
	assign sat_p    = sat32(rnd);
	assign m_wide   = 64'(sat_p.v) - ((j_q <= i_q) ? 64'(a_q) : 64'sd0);
	assign sat_m    = sat32(m_wide);
	assign sat_c    = sat32(acc_q);
	assign num_wide = 64'(sat_p.v) - 64'(sat_c.v) - lsum_q;
	assign sat_n    = sat32(num_wide);
	assign num_mag  = sat_n.v[31] ? (~sat_n.v + 32'd1) : sat_n.v;
	assign piv_mag  = piv_q[31] ? (~piv_q + 32'd1) : piv_q;

	// Divider step.
	assign rem_sh = {rem_q, quo_q[DW-1]};
	assign ge     = (rem_sh >= {1'b0, dvs_q});

	// Quotient sign and saturation.
	always_comb begin
		quo_ovf = neg_q ? ((|quo_q[DW-1:32]) || (quo_q[31] && (|quo_q[30:0])))
			: (|quo_q[DW-1:31]);
		if (state_q == S_DIV_END) begin
			if (quo_ovf) begin
				xw_data = neg_q ? 32'sh80000000 : 32'sh7FFFFFFF;
			end else begin
				xw_data = neg_q ? (~quo_q[31:0] + 32'd1) : quo_q[31:0];
			end
		end else begin
			xw_data = 32'sd0;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && operation == OP_START) begin
					state_d = (sweeps_q == 16'd0) ? S_OUT_RD : S_C_RD;
				end
			end
			S_C_RD:  state_d = S_C_M1;
			S_C_M1:  state_d = S_C_M2;
			S_C_M2:  state_d = S_C_M3;
			S_C_M3:  state_d = S_C_ACC;
			S_C_ACC: begin
				if (j_q == n_q - cnt_t'(1)) begin
					state_d = (i_q == cnt_t'(0)) ? S_T_RD : S_L_RD;
				end else begin
					state_d = S_C_RD;
				end
			end
			S_L_RD:  state_d = S_L_M1;
			S_L_M1:  state_d = S_L_ACC;
			S_L_ACC: state_d = (j_q == i_q - cnt_t'(1)) ? S_T_RD : S_L_RD;
			S_T_RD:  state_d = S_T_M1;
			S_T_M1:  state_d = S_T_NUM;
			S_T_NUM: state_d = (piv_q == 32'sd0) ? S_ROW_END : S_DIV;
			S_DIV:   state_d = (dcnt_q == DCW'(DW - 1)) ? S_DIV_END : S_DIV;
			S_DIV_END: state_d = S_ROW_END;
			S_ROW_END: begin
				if (is_last && s_q == sweeps_q - 16'd1) begin
					state_d = S_OUT_RD;
				end else begin
					state_d = S_C_RD;
				end
			end
			S_OUT_RD: state_d = S_OUT_V;
			S_OUT_V: begin
				if (!out_stall) begin
					state_d = is_last ? S_IDLE : S_OUT_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs: memory addresses, strobes and multiplier operands.
	always_comb begin
		col_sel   = (state_q == S_T_RD) ? i_q : j_q;
		mat_raddr = MW'(32'(i_q) * MAX_SIZE + 32'(col_sel));
		mat_waddr = MW'(32'(row) * MAX_SIZE + 32'(column));
		x_raddr   = AW'((state_q == S_OUT_RD || state_q == S_OUT_V) ? i_q : j_q);
		rhs_raddr = AW'(i_q);
		load_addr = AW'(row);
		xw_addr   = AW'(i_q);
		mat_we    = accept && operation == OP_MATRIX &&
			32'(row) < MAX_SIZE && 32'(column) < MAX_SIZE;
		rhs_we    = accept && operation == OP_RHS && 32'(row) < MAX_SIZE;
		load_x    = accept && operation == OP_GUESS && 32'(row) < MAX_SIZE;
		xw_en     = (state_q == S_DIV_END) ||
			(state_q == S_T_NUM && piv_q == 32'sd0);
		// Loads go to the row's current bank, solver writes to the other one.
		x0_we     = (load_x && !sel_q[load_addr]) || (xw_en && sel_q[xw_addr]);
		x1_we     = (load_x && sel_q[load_addr]) || (xw_en && !sel_q[xw_addr]);
		x0_waddr  = load_x ? load_addr : xw_addr;
		x1_waddr  = load_x ? load_addr : xw_addr;
		x0_wdata  = load_x ? value : xw_data;
		x1_wdata  = load_x ? value : xw_data;
		case (state_q)
			S_C_M3: begin
				mul_a = mterm_q;
				mul_b = x_q;
			end
			S_L_M1: begin
				mul_a = $signed(mat_rd);
				mul_b = new_rd;
			end
			S_T_M1: begin
				mul_a = tau_q;
				mul_b = $signed(rhs_rd);
			end
			default: begin
				mul_a = tau_q;
				mul_b = $signed(mat_rd);
			end
		endcase
	end

	// Result channel.
	assign out_valid      = (state_q == S_OUT_V);
	assign element_index  = i_q[3:0];
	assign solution_value = cur_rd;
	assign last           = is_last;
	assign status         = zp_q ? STATUS_PIVOT : (sat_q ? STATUS_SAT : STATUS_OK);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= 5'd16;
			sweeps_q <= 16'd1;
			tau_q    <= 32'sd65536;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SIZE:  size_q   <= cfg_data[4:0];
				REG_SWEEP: sweeps_q <= cfg_data[15:0];
				REG_TAU:   tau_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= cnt_t'(1);
			i_q     <= '0;
			j_q     <= '0;
			s_q     <= '0;
			sel_q   <= '0;
			sat_q   <= 1'b0;
			zp_q    <= 1'b0;
			dcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (accept && operation == OP_START) begin
						n_q   <= n_start;
						i_q   <= '0;
						j_q   <= '0;
						s_q   <= '0;
						sat_q <= 1'b0;
						zp_q  <= 1'b0;
					end
				end
				S_C_M2: sat_q <= sat_q | sat_p.ovf | sat_m.ovf;
				S_C_ACC: begin
					j_q <= (j_q == n_q - cnt_t'(1)) ? cnt_t'(0) : j_q + cnt_t'(1);
				end
				S_L_ACC: j_q <= j_q + cnt_t'(1);
				S_T_NUM: begin
					sat_q  <= sat_q | sat_p.ovf | sat_c.ovf | sat_n.ovf;
					zp_q   <= zp_q | (piv_q == 32'sd0);
					dcnt_q <= '0;
				end
				S_DIV: dcnt_q <= dcnt_q + DCW'(1);
				S_DIV_END: sat_q <= sat_q | quo_ovf;
				S_ROW_END: begin
					j_q <= '0;
					if (is_last) begin
						i_q   <= '0;
						sel_q <= sel_q ^ row_mask;
						s_q   <= s_q + 16'd1;
					end else begin
						i_q <= i_q + cnt_t'(1);
					end
				end
				S_OUT_V: begin
					if (!out_stall) begin
						i_q <= is_last ? cnt_t'(0) : i_q + cnt_t'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers: shared multiplier, accumulators and divider.
	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		case (state_q)
			S_IDLE, S_ROW_END: begin
				acc_q  <= '0;
				lsum_q <= '0;
			end
			S_C_M1: begin
				a_q <= $signed(mat_rd);
				x_q <= cur_rd;
			end
			S_C_M2: mterm_q <= sat_m.v;
			S_C_ACC: acc_q <= acc_q + rnd;
			S_L_ACC: lsum_q <= lsum_q + rnd;
			S_T_M1: piv_q <= $signed(mat_rd);
			S_T_NUM: begin
				neg_q <= sat_n.v[31] ^ piv_q[31];
				dvs_q <= piv_mag;
				rem_q <= '0;
				quo_q <= DW'(num_mag) << FRAC_BITS;
			end
			S_DIV: begin
				rem_q <= ge ? 32'(rem_sh - {1'b0, dvs_q}) : rem_sh[31:0];
				quo_q <= {quo_q[DW-2:0], ge};
			end
			default: ;
		endcase
	end

	// Stores.
	rlss_ram #(.WIDTH(32), .DEPTH(MD)) u_mat (
		.clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(value),
		.raddr(mat_raddr), .rdata(mat_rd)
	);

	rlss_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_rhs (
		.clk(clk), .we(rhs_we), .waddr(load_addr), .wdata(value),
		.raddr(rhs_raddr), .rdata(rhs_rd)
	);

	rlss_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_x0 (
		.clk(clk), .we(x0_we), .waddr(x0_waddr), .wdata(x0_wdata),
		.raddr(x_raddr), .rdata(x0_rd)
	);

	rlss_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_x1 (
		.clk(clk), .we(x1_we), .waddr(x1_waddr), .wdata(x1_wdata),
		.raddr(x_raddr), .rdata(x1_rd)
	);

endmodule

FILE: src/rlss_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlss_chk
// Port-level checks of the solver, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rlss_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [1:0]         operation,
	input logic               out_valid,
	input logic               out_stall,
	input logic [3:0]         element_index,
	input logic signed [31:0] solution_value,
	input logic               last,
	input logic [1:0]         status
);
	import rlss_pkg::*;

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(solution_value))
		else $error("stalled result changed");

	// No new request is taken while results are delivered.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request taken during output");

	// A start request makes the block busy.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && operation == OP_START |=> in_stall)
		else $error("start request did not occupy the block");

	// Elements follow in order with one status per run.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> ##1 (out_valid &&
		element_index == $past(element_index, 2) + 4'd1 &&
		status == $past(status, 2)))
		else $error("element order or status broken");

	// The last element ends the run.
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last |=> !out_valid)
		else $error("result after last element");

endmodule

bind relaxed_lower_splitting_solver_top rlss_chk u_rlss_chk (.*);
